### design/lidar_pulse_closing_speed_macros.svh
// ----------------------------------------------------------------------------
// Lidar pulse closing speed: assertion macros
// Shared concurrent assertion forms, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LIDAR_PULSE_CLOSING_SPEED_MACROS_SVH
`define LIDAR_PULSE_CLOSING_SPEED_MACROS_SVH

`ifndef SYNTHESIS

`define LPCS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpcs assertion failed");

`define LPCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpcs assertion failed");

`else

`define LPCS_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define LPCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### design/lpcs_pkg.sv
// ----------------------------------------------------------------------------
// Lidar pulse closing speed: package
// Field widths, register reset value and scaling constants.
// ----------------------------------------------------------------------------
package lpcs_pkg;

    localparam int ADC_W               = 8;
    localparam int DIST_W              = 12;
    localparam int SPEED_W             = 9;
    localparam int DUTY_W              = 8;

    localparam int COUNT_WIDTH_DEFAULT = 12;

    localparam logic [ADC_W-1:0] THRESHOLD_RESET = ADC_W'(50);

    localparam int DIST_OUT_MAX        = 4095;
    localparam int SPEED_OUT_MAX       = 511;

    // The scale factor 72/1000 reduced to lowest terms.
    localparam int SCALE_NUM           = 9;
    localparam int SCALE_DEN           = 125;

    localparam int LAMP_LIMIT          = 25;
    localparam int LAMP_GAIN           = 10;
    localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(255);
    localparam logic [DUTY_W-1:0] DUTY_OFF  = DUTY_W'(0);

endpackage

### design/lpcs_if.sv
// ----------------------------------------------------------------------------
// Lidar pulse closing speed: channel interfaces
// Valid/ready channels for sample words and result words.
// ----------------------------------------------------------------------------
interface lpcs_sample_if;
    import lpcs_pkg::*;

    logic             valid;
    logic             ready;
    logic [ADC_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink (input valid, input adc_sample, output ready);
endinterface

interface lpcs_result_if;
    import lpcs_pkg::*;

    logic               valid;
    logic               ready;
    logic [DIST_W-1:0]  distance_count;
    logic [SPEED_W-1:0] closing_speed;
    logic               approaching;
    logic [DUTY_W-1:0]  duty_slow;
    logic [DUTY_W-1:0]  duty_hold;
    logic [DUTY_W-1:0]  duty_faster;

    modport source (
        output valid, output distance_count, output closing_speed, output approaching,
        output duty_slow, output duty_hold, output duty_faster, input ready
    );
    modport sink (
        input valid, input distance_count, input closing_speed, input approaching,
        input duty_slow, input duty_hold, input duty_faster, output ready
    );
endinterface

### design/lpcs_front.sv
// ----------------------------------------------------------------------------
// Lidar pulse closing speed: pulse front end
// Threshold compare, width counter and distance difference stage.
// ----------------------------------------------------------------------------
`include "lidar_pulse_closing_speed_macros.svh"

module lpcs_front #(
    parameter int COUNT_WIDTH = lpcs_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [lpcs_pkg::ADC_W-1:0] cfg_wr_data,
    lpcs_sample_if.sink                samples,
    input  logic                       mid_adv,
    output logic                       mid_valid,
    output logic                       mid_near,
    output logic [COUNT_WIDTH-1:0]     mid_dist,
    output logic [COUNT_WIDTH-1:0]     mid_diff
);
    import lpcs_pkg::*;

    logic [ADC_W-1:0]       threshold_reg;
    logic [ADC_W-1:0]       threshold_next;
    logic                   armed_reg;
    logic                   armed_next;
    logic [COUNT_WIDTH-1:0] width_count_reg;
    logic [COUNT_WIDTH-1:0] width_count_next;
    logic [COUNT_WIDTH-1:0] last_distance_reg;
    logic [COUNT_WIDTH-1:0] last_distance_next;
    logic                   mid_valid_reg;
    logic                   mid_valid_next;
    logic                   mid_near_reg;
    logic [COUNT_WIDTH-1:0] mid_dist_reg;
    logic [COUNT_WIDTH-1:0] mid_diff_reg;

    logic                   sample_acc;
    logic                   is_high;
    logic                   pulse_end;
    logic                   dist_near;
    logic [COUNT_WIDTH-1:0] dist_diff;

    assign samples.ready = !mid_valid_reg || mid_adv;
    assign sample_acc    = samples.valid && samples.ready;
    assign is_high       = samples.adc_sample > threshold_reg;
    assign pulse_end     = sample_acc && armed_reg && !is_high;

    assign dist_near = width_count_reg <= last_distance_reg;
    assign dist_diff = dist_near ? (last_distance_reg - width_count_reg)
                                 : (width_count_reg - last_distance_reg);

    always_comb
    begin
        threshold_next     = cfg_wr_en ? cfg_wr_data : threshold_reg;
        armed_next         = armed_reg;
        width_count_next   = width_count_reg;
        last_distance_next = last_distance_reg;
        mid_valid_next     = mid_valid_reg && !mid_adv;
        if (sample_acc)
        begin
            if (!armed_reg)
            begin
                armed_next = is_high;
            end
            else if (is_high)
            begin
                if (!(&width_count_reg))
                begin
                    width_count_next = width_count_reg + COUNT_WIDTH'(1);
                end
            end
            else
            begin
                armed_next         = 1'b0;
                width_count_next   = '0;
                last_distance_next = width_count_reg;
                mid_valid_next     = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg     <= THRESHOLD_RESET;
            armed_reg         <= 1'b0;
            width_count_reg   <= '0;
            last_distance_reg <= '0;
            mid_valid_reg     <= 1'b0;
        end
        else
        begin
            threshold_reg     <= threshold_next;
            armed_reg         <= armed_next;
            width_count_reg   <= width_count_next;
            last_distance_reg <= last_distance_next;
            mid_valid_reg     <= mid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pulse_end)
        begin
            mid_near_reg <= dist_near;
            mid_dist_reg <= width_count_reg;
            mid_diff_reg <= dist_diff;
        end
    end

    assign mid_valid = mid_valid_reg;
    assign mid_near  = mid_near_reg;
    assign mid_dist  = mid_dist_reg;
    assign mid_diff  = mid_diff_reg;

    `LPCS_ASSERT_NEXT(a_end_gives_word, clk, rst_n, pulse_end, mid_valid_reg)
    `LPCS_ASSERT_NEXT(a_end_clears, clk, rst_n, pulse_end, !armed_reg && width_count_reg == '0)
    `LPCS_ASSERT_NEXT(a_mid_holds, clk, rst_n, mid_valid_reg && !mid_adv, mid_valid_reg && $stable(mid_diff_reg) && $stable(mid_dist_reg))

endmodule

### design/lpcs_speed.sv
// ----------------------------------------------------------------------------
// Lidar pulse closing speed: speed and lamp stage
// Scales the distance change, sets the lamp duties and holds the result word.
// ----------------------------------------------------------------------------
module lpcs_speed #(
    parameter int COUNT_WIDTH = lpcs_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   mid_valid,
    input  logic                   mid_near,
    input  logic [COUNT_WIDTH-1:0] mid_dist,
    input  logic [COUNT_WIDTH-1:0] mid_diff,
    output logic                   mid_adv,
    lpcs_result_if.source          results
);
    import lpcs_pkg::*;

    // Division by the denominator is a multiply by a rounded-up reciprocal.
    localparam int YW = COUNT_WIDTH + 4;
    localparam int K  = YW + 7;
    localparam int MW = YW + 1;
    localparam int QW = COUNT_WIDTH - 2;
    localparam logic [MW-1:0] RECIP = MW'(((64'd1 << K) + SCALE_DEN - 1) / SCALE_DEN);

    logic [YW-1:0]      scaled;
    logic [YW+MW-1:0]   product;
    logic [QW-1:0]      quotient;
    logic [SPEED_W-1:0] speed;
    logic [DIST_W-1:0]  dist_out;
    logic [DUTY_W-1:0]  lamp;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [DIST_W-1:0]  distance_count_reg;
    logic [SPEED_W-1:0] closing_speed_reg;
    logic               approaching_reg;
    logic [DUTY_W-1:0]  duty_slow_reg;
    logic [DUTY_W-1:0]  duty_hold_reg;
    logic [DUTY_W-1:0]  duty_faster_reg;

    assign scaled   = YW'(mid_diff) * YW'(SCALE_NUM);
    assign product  = (YW+MW)'(scaled) * (YW+MW)'(RECIP);
    assign quotient = product[K +: QW];

    generate
        if (QW > SPEED_W)
        begin : g_speed_sat
            assign speed = (quotient > QW'(SPEED_OUT_MAX)) ? SPEED_W'(SPEED_OUT_MAX)
                                                          : SPEED_W'(quotient);
        end
        else
        begin : g_speed_ext
            assign speed = SPEED_W'(quotient);
        end
        if (COUNT_WIDTH > DIST_W)
        begin : g_dist_sat
            assign dist_out = (mid_dist > COUNT_WIDTH'(DIST_OUT_MAX)) ? DIST_W'(DIST_OUT_MAX)
                                                                     : DIST_W'(mid_dist);
        end
        else
        begin : g_dist_ext
            assign dist_out = DIST_W'(mid_dist);
        end
    endgenerate

    assign lamp = (speed < SPEED_W'(LAMP_LIMIT)) ? (speed[DUTY_W-1:0] * DUTY_W'(LAMP_GAIN))
                                                 : DUTY_FULL;

    assign mid_adv        = !out_valid_reg || results.ready;
    assign out_valid_next = mid_adv ? mid_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_adv && mid_valid)
        begin
            distance_count_reg <= dist_out;
            closing_speed_reg  <= speed;
            approaching_reg    <= mid_near;
            if (speed == '0)
            begin
                duty_slow_reg   <= DUTY_OFF;
                duty_hold_reg   <= DUTY_FULL;
                duty_faster_reg <= DUTY_OFF;
            end
            else if (mid_near)
            begin
                duty_slow_reg   <= lamp;
                duty_hold_reg   <= DUTY_OFF;
                duty_faster_reg <= DUTY_OFF;
            end
            else
            begin
                duty_slow_reg   <= DUTY_OFF;
                duty_hold_reg   <= DUTY_OFF;
                duty_faster_reg <= lamp;
            end
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.distance_count = distance_count_reg;
    assign results.closing_speed  = closing_speed_reg;
    assign results.approaching    = approaching_reg;
    assign results.duty_slow      = duty_slow_reg;
    assign results.duty_hold      = duty_hold_reg;
    assign results.duty_faster    = duty_faster_reg;

endmodule

### design/lidar_pulse_closing_speed.sv
// ----------------------------------------------------------------------------
// Lidar pulse closing speed: top level
// Measures rangefinder pulse widths and reports distance and closing speed.
// ----------------------------------------------------------------------------
// The block takes one sample word in every clock cycle while samples.ready
// is high. A sample above the threshold first arms the counter and then
// widens the pulse by one; the first sample at or below it closes the pulse,
// and its result word passes the difference stage and then the speed stage
// with its single reciprocal multiplier. A waiting result word does not
// stop input: samples are refused only when both the difference stage and
// the result register are full and the sink is not ready.
module lidar_pulse_closing_speed #(
    parameter int COUNT_WIDTH = lpcs_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [lpcs_pkg::ADC_W-1:0] cfg_wr_data,
    lpcs_sample_if.sink                samples,
    lpcs_result_if.source              results
);
    import lpcs_pkg::*;

    logic                   mid_valid;
    logic                   mid_near;
    logic [COUNT_WIDTH-1:0] mid_dist;
    logic [COUNT_WIDTH-1:0] mid_diff;
    logic                   mid_adv;

    lpcs_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .samples     (samples),
        .mid_adv     (mid_adv),
        .mid_valid   (mid_valid),
        .mid_near    (mid_near),
        .mid_dist    (mid_dist),
        .mid_diff    (mid_diff)
    );

    lpcs_speed #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_speed (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_valid (mid_valid),
        .mid_near  (mid_near),
        .mid_dist  (mid_dist),
        .mid_diff  (mid_diff),
        .mid_adv   (mid_adv),
        .results   (results)
    );

endmodule

### verif/lidar_pulse_closing_speed_test.sv
// ----------------------------------------------------------------------------
// Lidar pulse closing speed: block-level test
// Feeds sample words through the valid/ready channel with bursty input and a
// stalling result sink. A built-in model of the pulse counter predicts each
// result word, which is then compared field by field in arrival order.
// Directed cases cover the reset threshold, every lamp outcome and the
// threshold extremes. Random pulse trains under changing thresholds follow.
// ----------------------------------------------------------------------------
module lidar_pulse_closing_speed_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lpcs_pkg::*;

    localparam int WIDTH_MAX    = (1 << COUNT_WIDTH_DEFAULT) - 1;
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_WORDS = 110;

    typedef struct {
        logic [DIST_W-1:0]  distance;
        logic [SPEED_W-1:0] speed;
        logic               approaching;
        logic [DUTY_W-1:0]  slow;
        logic [DUTY_W-1:0]  hold;
        logic [DUTY_W-1:0]  faster;
    } pulse_report_t;

    typedef enum int {READY_ALWAYS, READY_RANDOM, READY_SPARSE} stall_mode_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [ADC_W-1:0] cfg_wr_data;

    lpcs_sample_if smp ();
    lpcs_result_if res ();

    lidar_pulse_closing_speed u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .samples     (smp.sink),
        .results     (res.source)
    );

    logic [ADC_W-1:0] threshold_reg;
    logic             armed;
    int               width_cnt;
    int               last_dist;
    pulse_report_t    report_q[$];
    pulse_report_t    head_report;

    int fail_count;
    int words_sent;
    int words_taken;
    int reports_checked;
    int settings_used;
    int burst_left;

    always #10 clk = ~clk;

    function automatic logic [DUTY_W-1:0] lamp_duty(input int spd);
        if (spd < LAMP_LIMIT)
            return DUTY_W'(LAMP_GAIN * spd);
        return DUTY_FULL;
    endfunction

    function automatic void predict_word(input logic [ADC_W-1:0] w);
        logic          high;
        int            pulse_dist;
        int            diff;
        int            spd;
        pulse_report_t r;
        high = (w > threshold_reg);
        if (!armed)
        begin
            if (high)
                armed = 1'b1;
        end
        else if (high)
        begin
            if (width_cnt < WIDTH_MAX)
                width_cnt++;
        end
        else
        begin
            pulse_dist = width_cnt;
            width_cnt = 0;
            armed = 1'b0;
            r.approaching = (pulse_dist <= last_dist);
            diff = r.approaching ? last_dist - pulse_dist : pulse_dist - last_dist;
            last_dist = pulse_dist;
            spd = (diff * 72) / 1000;
            if (spd > SPEED_OUT_MAX)
                spd = SPEED_OUT_MAX;
            r.distance = DIST_W'((pulse_dist > DIST_OUT_MAX) ? DIST_OUT_MAX : pulse_dist);
            r.speed = SPEED_W'(spd);
            r.slow = DUTY_OFF;
            r.hold = DUTY_OFF;
            r.faster = DUTY_OFF;
            if (spd == 0)
                r.hold = DUTY_FULL;
            else if (r.approaching)
                r.slow = lamp_duty(spd);
            else
                r.faster = lamp_duty(spd);
            report_q.push_back(r);
        end
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res.valid && res.ready)
            begin
                if (report_q.size() == 0)
                begin
                    $error("result word with no pending report, distance_count %0d",
                           res.distance_count);
                    fail_count++;
                end
                else
                begin
                    head_report = report_q.pop_front();
                    check_field("distance_count", head_report.distance, res.distance_count);
                    check_field("closing_speed", head_report.speed, res.closing_speed);
                    check_field("approaching", head_report.approaching, res.approaching);
                    check_field("duty_slow", head_report.slow, res.duty_slow);
                    check_field("duty_hold", head_report.hold, res.duty_hold);
                    check_field("duty_faster", head_report.faster, res.duty_faster);
                    reports_checked++;
                end
            end
            if (smp.valid && smp.ready)
            begin
                predict_word(smp.adc_sample);
                words_taken++;
            end
        end
    end

    initial
    begin
        stall_mode_t mode;
        int          mode_left;
        mode = READY_ALWAYS;
        mode_left = 0;
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode = stall_mode_t'($urandom_range(2));
                mode_left = $urandom_range(80, 20);
            end
            mode_left--;
            case (mode)
                READY_ALWAYS: res.ready <= 1'b1;
                READY_RANDOM: res.ready <= 1'($urandom_range(1));
                default:      res.ready <= ($urandom_range(4) == 0);
            endcase
        end
    end

    task automatic send_word(input logic [ADC_W-1:0] w);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
            if (gap > 0)
            begin
                smp.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(7) == 0) ? 150 : $urandom_range(12, 1);
        end
        smp.valid <= 1'b1;
        smp.adc_sample <= w;
        @(posedge clk);
        while (!smp.ready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        words_sent++;
    endtask

    function automatic logic [ADC_W-1:0] high_word();
        return ADC_W'($urandom_range(255, int'(threshold_reg) + 1));
    endfunction

    function automatic logic [ADC_W-1:0] low_word();
        return ADC_W'($urandom_range(int'(threshold_reg), 0));
    endfunction

    task automatic send_pulse(input int width);
        send_word(high_word());
        repeat (width) send_word(high_word());
        send_word(low_word());
    endtask

    task automatic wait_idle();
        smp.valid <= 1'b0;
        burst_left = 0;
        while (report_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_threshold(input logic [ADC_W-1:0] value);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        threshold_reg = value;
        settings_used++;
    endtask

    task automatic test_reset_threshold();
        send_word(8'd50);
        send_word(8'd0);
        send_word(8'd51);
        send_word(8'd51);
        send_word(8'd255);
        send_word(8'd200);
        send_word(8'd50);
        send_word(8'd255);
        send_word(8'd0);
        send_pulse(0);
    endtask

    task automatic test_lamps();
        send_pulse(348);
        send_pulse(14);
        send_pulse(0);
        send_pulse(14);
        send_pulse(14);
        send_pulse(1);
    endtask

    task automatic test_threshold_extremes();
        write_threshold(8'd255);
        send_word(8'd255);
        repeat (12) send_word(ADC_W'($urandom_range(255)));
        send_word(8'd0);
        write_threshold(8'd0);
        send_word(8'd0);
        send_word(8'd1);
        send_word(8'd255);
        send_word(8'd128);
        send_word(8'd0);
        send_pulse(3);
        write_threshold(8'd254);
        send_word(8'd255);
        send_word(8'd255);
        send_word(8'd254);
    endtask

    task automatic test_random_pulses();
        int pulse_words;
        int phase_words;
        int width;
        int pick;
        pulse_words = 0;
        phase_words = 0;
        while (pulse_words < RANDOM_WORDS)
        begin
            if (phase_words == 0)
            begin
                pick = $urandom_range(7);
                if (pick == 0)
                    write_threshold(8'd0);
                else if (pick == 1)
                    write_threshold(8'd254);
                else
                    write_threshold(ADC_W'($urandom_range(254)));
                phase_words = $urandom_range(60, 30);
            end
            repeat ($urandom_range(3)) send_word(low_word());
            pick = $urandom_range(99);
            if (pick < 70)
                width = $urandom_range(12);
            else
                width = $urandom_range(40, 13);
            send_pulse(width);
            pulse_words += width + 2;
            phase_words = (phase_words > width + 2) ? phase_words - (width + 2) : 0;
        end
    endtask

    initial
    begin
        smp.valid = 1'b0;
        smp.adc_sample = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        rst_n = 1'b0;
        threshold_reg = THRESHOLD_RESET;
        armed = 1'b0;
        width_cnt = 0;
        last_dist = 0;
        fail_count = 0;
        words_sent = 0;
        words_taken = 0;
        reports_checked = 0;
        settings_used = 0;
        burst_left = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_threshold();
        test_lamps();
        test_threshold_extremes();
        test_random_pulses();
        wait_idle();

        $display("Sent %0d sample words (%0d taken) under %0d threshold settings.",
                 words_sent, words_taken, settings_used);
        $display("Checked %0d pulse reports, covering every lamp outcome and threshold edge.",
                 reports_checked);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule
